// ===== src/rgba_pixel_compositor_defines.svh =====
// Assertion macros for the pixel compositor.
`ifndef RGBA_PIXEL_COMPOSITOR_DEFINES_SVH
`define RGBA_PIXEL_COMPOSITOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked property, disabled while reset is high.
`define RPC_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, active during reset as well.
`define RPC_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPC_ASSERT_RST(lbl, clk, rst, prop, msg)
`define RPC_ASSERT(lbl, clk, prop, msg)
`endif

`endif

// ===== src/rpc_pkg.sv =====
package rpc_pkg;

   localparam int CHANNEL_BITS_DEF = 16;

   // Configuration register indexes
   localparam logic CSR_MIX_WEIGHT = 1'b0;
   localparam logic CSR_BLEND_MODE = 1'b1;

   // Blend modes
   localparam logic MODE_CROSSFADE = 1'b0;
   localparam logic MODE_OVER      = 1'b1;

   // How the result pixel is formed, decided at the first stage
   typedef enum logic [2:0] {
      KIND_ZERO   = 3'd0,
      KIND_PASS_A = 3'd1,
      KIND_COPY_A = 3'd2,
      KIND_COPY_B = 3'd3,
      KIND_BLEND  = 3'd4
   } kind_type;

endpackage

// ===== src/rgba_pixel_compositor.sv =====
// RGBA pixel compositor: crossfade of A and B, or B over A.
// Request channel (req_*): one pixel position per item, RGBA of pixel A and
// pixel B plus a presence flag for each. Result channel (rsp_*): one blended
// RGBA pixel per item, with res_covered set when either pixel was present.
// Both channels move an item on a clock edge with valid high and stall low.
// Config channel (csr_*): index 0 is the mix weight (2^CHANNEL_BITS = 1.0,
// larger values clamp), index 1 the blend mode (0 crossfade, 1 B over A);
// csr_ready is always high. Write config only while the pipe is empty.
// Throughput: one item per clock while the result channel does not stall.
// Stages: four weight/product stages, a restoring divider resolving one
// quotient bit per stage for the color channels, then the output register.
// Reset (synchronous, active high) empties the pipe and clears both config
// registers. When the receiver stalls with a result pending, the whole pipe
// holds and req_stall rises in the same cycle; nothing is dropped.
`include "rgba_pixel_compositor_defines.svh"

module rgba_pixel_compositor import rpc_pkg::*; #(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // config
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_index,
   input  logic [CHANNEL_BITS:0]   csr_data,
   // request
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [CHANNEL_BITS-1:0] req_a_red,
   input  logic [CHANNEL_BITS-1:0] req_a_green,
   input  logic [CHANNEL_BITS-1:0] req_a_blue,
   input  logic [CHANNEL_BITS-1:0] req_a_alpha,
   input  logic [CHANNEL_BITS-1:0] req_b_red,
   input  logic [CHANNEL_BITS-1:0] req_b_green,
   input  logic [CHANNEL_BITS-1:0] req_b_blue,
   input  logic [CHANNEL_BITS-1:0] req_b_alpha,
   input  logic                    req_a_present,
   input  logic                    req_b_present,
   // result
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [CHANNEL_BITS-1:0] rsp_res_red,
   output logic [CHANNEL_BITS-1:0] rsp_res_green,
   output logic [CHANNEL_BITS-1:0] rsp_res_blue,
   output logic [CHANNEL_BITS-1:0] rsp_res_alpha,
   output logic                    rsp_res_covered
);

   localparam int W        = CHANNEL_BITS;
   localparam int NUM_BITS = 2 * W + 1;
   localparam int LANES    = 3;
   localparam logic [W:0] ONE = (W + 1)'(1) << W;

   typedef struct packed {
      kind_type       kind;
      logic           covered;
      logic [W-1:0]   a_red;
      logic [W-1:0]   a_green;
      logic [W-1:0]   a_blue;
      logic [W-1:0]   a_alpha;
      logic [W-1:0]   b_red;
      logic [W-1:0]   b_green;
      logic [W-1:0]   b_blue;
      logic [W-1:0]   b_alpha;
      logic [W-1:0]   wa;
      logic [W-1:0]   wb;
      logic [W:0]     sum;
   } side_type;

   // ---------------- configuration ----------------
   logic [W:0] mix_ff;
   logic       mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_ff  <= '0;
         mode_ff <= MODE_CROSSFADE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIX_WEIGHT: mix_ff  <= csr_data;
            CSR_BLEND_MODE: mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic en;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = rsp_valid_ff;

   // ---------------- stage A: mix clamp, weighted alphas, kind ----------------
   logic [W:0]          mb;
   logic [W:0]          ma;
   logic [NUM_BITS-1:0] wa_cf_prod;
   logic [NUM_BITS-1:0] wb_prod;
   side_type            sa_side_in, sa_side_ff;
   logic                sa_vld_ff;

   assign mb         = (mix_ff > ONE) ? ONE : mix_ff;
   assign ma         = ONE - mb;
   assign wa_cf_prod = NUM_BITS'(req_a_alpha) * NUM_BITS'(ma);
   assign wb_prod    = NUM_BITS'(req_b_alpha) * NUM_BITS'(mb);

   always_comb begin
      sa_side_in.a_red   = req_a_red;
      sa_side_in.a_green = req_a_green;
      sa_side_in.a_blue  = req_a_blue;
      sa_side_in.a_alpha = req_a_alpha;
      sa_side_in.b_red   = req_b_red;
      sa_side_in.b_green = req_b_green;
      sa_side_in.b_blue  = req_b_blue;
      sa_side_in.b_alpha = req_b_alpha;
      sa_side_in.covered = req_a_present || req_b_present;
      sa_side_in.wa      = wa_cf_prod[2*W-1:W];
      sa_side_in.wb      = wb_prod[2*W-1:W];
      sa_side_in.sum     = '0;
      sa_side_in.kind    = KIND_ZERO;
      if (mode_ff == MODE_CROSSFADE) begin
         if (req_a_present && req_b_present) begin
            sa_side_in.kind = KIND_BLEND;
         end else if (req_a_present) begin
            sa_side_in.kind = (ma == '0) ? KIND_ZERO : KIND_COPY_A;
         end else if (req_b_present) begin
            sa_side_in.kind = (mb == '0) ? KIND_ZERO : KIND_COPY_B;
         end
      end else begin
         if (req_a_present && req_b_present) begin
            sa_side_in.kind = (mb == '0) ? KIND_PASS_A : KIND_BLEND;
         end else if (req_a_present) begin
            sa_side_in.kind = KIND_PASS_A;
         end else if (req_b_present) begin
            sa_side_in.kind = (mb == '0) ? KIND_ZERO : KIND_COPY_B;
         end
      end
   end

   // ---------------- stage B: over-mode weight of A, summed alpha ----------------
   logic                mode_b_ff;
   logic [NUM_BITS-1:0] wa_ov_prod;
   side_type            sb_side_in, sb_side_ff;
   logic                sb_vld_ff;

   assign wa_ov_prod = NUM_BITS'(sa_side_ff.a_alpha) * NUM_BITS'(ONE - {1'b0, sa_side_ff.wb});

   always_comb begin
      sb_side_in = sa_side_ff;
      if (mode_b_ff == MODE_OVER) begin
         sb_side_in.wa = wa_ov_prod[2*W-1:W];
      end
      sb_side_in.sum = {1'b0, sb_side_in.wa} + {1'b0, sb_side_in.wb};
   end

   // ---------------- stage C: color products ----------------
   logic [W-1:0]   sb_ca [0:LANES-1];
   logic [W-1:0]   sb_cb [0:LANES-1];
   logic [2*W-1:0] prod_a_ff [0:LANES-1];
   logic [2*W-1:0] prod_b_ff [0:LANES-1];
   side_type       sc_side_ff;
   logic           sc_vld_ff;

   assign sb_ca[0] = sb_side_ff.a_red;
   assign sb_ca[1] = sb_side_ff.a_green;
   assign sb_ca[2] = sb_side_ff.a_blue;
   assign sb_cb[0] = sb_side_ff.b_red;
   assign sb_cb[1] = sb_side_ff.b_green;
   assign sb_cb[2] = sb_side_ff.b_blue;

   // ---------------- stage D and divider: one quotient bit per stage ----------------
   logic [NUM_BITS-1:0] rem_ff [0:W][0:LANES-1];
   logic [NUM_BITS-1:0] rem_in [1:W][0:LANES-1];
   logic [W-1:0]        q_ff   [0:W][0:LANES-1];
   logic [W-1:0]        q_in   [1:W][0:LANES-1];
   logic [NUM_BITS-1:0] dsh    [0:W-1];
   side_type            side_ff [0:W];
   logic                vld_ff  [0:W];

   always_comb begin
      for (int s = 0; s < W; s++) begin
         dsh[s] = NUM_BITS'(side_ff[s].sum) << (W - 1 - s);
         for (int l = 0; l < LANES; l++) begin
            if (rem_ff[s][l] >= dsh[s]) begin
               rem_in[s+1][l] = rem_ff[s][l] - dsh[s];
               q_in[s+1][l]   = q_ff[s][l] | (W'(1) << (W - 1 - s));
            end else begin
               rem_in[s+1][l] = rem_ff[s][l];
               q_in[s+1][l]   = q_ff[s][l];
            end
         end
      end
   end

   // ---------------- output select ----------------
   side_type     fin;
   logic [W-1:0] res_red_in, res_green_in, res_blue_in, res_alpha_in;
   logic [W-1:0] res_red_ff, res_green_ff, res_blue_ff, res_alpha_ff;
   logic         res_covered_ff;

   assign fin = side_ff[W];

   always_comb begin
      res_red_in   = '0;
      res_green_in = '0;
      res_blue_in  = '0;
      res_alpha_in = '0;
      case (fin.kind)
         KIND_PASS_A: begin
            res_red_in   = fin.a_red;
            res_green_in = fin.a_green;
            res_blue_in  = fin.a_blue;
            res_alpha_in = fin.a_alpha;
         end
         KIND_COPY_A: begin
            res_red_in   = fin.a_red;
            res_green_in = fin.a_green;
            res_blue_in  = fin.a_blue;
            res_alpha_in = fin.wa;
         end
         KIND_COPY_B: begin
            res_red_in   = fin.b_red;
            res_green_in = fin.b_green;
            res_blue_in  = fin.b_blue;
            res_alpha_in = fin.wb;
         end
         KIND_BLEND: begin
            // zero summed alpha gives an empty pixel
            if (fin.sum != '0) begin
               res_red_in   = q_ff[W][0];
               res_green_in = q_ff[W][1];
               res_blue_in  = q_ff[W][2];
               res_alpha_in = fin.sum[W] ? {W{1'b1}} : fin.sum[W-1:0];
            end
         end
         default: ;
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sa_vld_ff    <= 1'b0;
         sb_vld_ff    <= 1'b0;
         sc_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s <= W; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (en) begin
         sa_vld_ff    <= req_valid;
         sb_vld_ff    <= sa_vld_ff;
         sc_vld_ff    <= sb_vld_ff;
         vld_ff[0]    <= sc_vld_ff;
         for (int s = 0; s < W; s++) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         rsp_valid_ff <= vld_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_side_ff <= sa_side_in;
         mode_b_ff  <= mode_ff;
         sb_side_ff <= sb_side_in;
         sc_side_ff <= sb_side_ff;
         for (int l = 0; l < LANES; l++) begin
            prod_a_ff[l] <= sb_ca[l] * sb_side_ff.wa;
            prod_b_ff[l] <= sb_cb[l] * sb_side_ff.wb;
            rem_ff[0][l] <= NUM_BITS'(prod_a_ff[l]) + NUM_BITS'(prod_b_ff[l]);
            q_ff[0][l]   <= '0;
         end
         side_ff[0] <= sc_side_ff;
         for (int s = 0; s < W; s++) begin
            side_ff[s+1] <= side_ff[s];
            for (int l = 0; l < LANES; l++) begin
               rem_ff[s+1][l] <= rem_in[s+1][l];
               q_ff[s+1][l]   <= q_in[s+1][l];
            end
         end
         res_red_ff     <= res_red_in;
         res_green_ff   <= res_green_in;
         res_blue_ff    <= res_blue_in;
         res_alpha_ff   <= res_alpha_in;
         res_covered_ff <= fin.covered;
      end
   end

   assign rsp_res_red     = res_red_ff;
   assign rsp_res_green   = res_green_ff;
   assign rsp_res_blue    = res_blue_ff;
   assign rsp_res_alpha   = res_alpha_ff;
   assign rsp_res_covered = res_covered_ff;

   // ---------------- assertions ----------------
   `RPC_ASSERT(a_stall_needs_result, clock, req_stall |-> rsp_valid_ff, "stall without result")
   `RPC_ASSERT_RST(a_enter_stage_a, clock, reset, (req_valid && !req_stall) |=> sa_vld_ff, "item lost at entry")
   `RPC_ASSERT_RST(a_blend_sum_fits, clock, reset, (vld_ff[W] && fin.kind == KIND_BLEND) |-> !fin.sum[W], "alpha sum overflow")
   `RPC_ASSERT_RST(a_uncovered_zero, clock, reset, (rsp_valid && !rsp_res_covered) |-> (rsp_res_red == '0 && rsp_res_green == '0 && rsp_res_blue == '0 && rsp_res_alpha == '0), "uncovered pixel not empty")

endmodule

// ===== dv/rgba_pixel_compositor_tb.sv =====
`timescale 1ns / 1ps

module rgba_pixel_compositor_tb import rpc_pkg::*; ();

   localparam int CB = CHANNEL_BITS_DEF;
   localparam longint unsigned ONE = 64'd1 << CB;
   localparam logic [CB:0] MIX_UNITY = (CB + 1)'(1) << CB;
   localparam int LATENCY = CB + 5;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER_ITEMS = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES = 12;
   localparam int ITEMS_PER_PHASE = 75;

   typedef struct packed {
      logic [CB-1:0] red;
      logic [CB-1:0] green;
      logic [CB-1:0] blue;
      logic [CB-1:0] alpha;
   } rgba_type;

   typedef struct packed {
      rgba_type a;
      rgba_type b;
      logic     a_present;
      logic     b_present;
   } pixel_pair_type;

   typedef struct packed {
      rgba_type color;
      logic     covered;
   } blended_type;

   localparam rgba_type FULL_PX  = '{'1, '1, '1, '1};
   localparam rgba_type EMPTY_PX = '{'0, '0, '0, '0};
   localparam rgba_type MID_PX   = '{16'h1234, 16'h8000, 16'hFEDC, 16'h8000};
   localparam rgba_type CLEAR_PX = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000};

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic          csr_index = CSR_MIX_WEIGHT;
   logic [CB:0]   csr_data = '0;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [CB-1:0] req_a_red = '0;
   logic [CB-1:0] req_a_green = '0;
   logic [CB-1:0] req_a_blue = '0;
   logic [CB-1:0] req_a_alpha = '0;
   logic [CB-1:0] req_b_red = '0;
   logic [CB-1:0] req_b_green = '0;
   logic [CB-1:0] req_b_blue = '0;
   logic [CB-1:0] req_b_alpha = '0;
   logic          req_a_present = 1'b0;
   logic          req_b_present = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [CB-1:0] rsp_res_red;
   logic [CB-1:0] rsp_res_green;
   logic [CB-1:0] rsp_res_blue;
   logic [CB-1:0] rsp_res_alpha;
   logic          rsp_res_covered;

   // Local copy of the configuration registers
   logic [CB:0] mix_cfg = '0;
   logic        mode_cfg = MODE_CROSSFADE;

   pixel_pair_type pixels_to_send[$];
   blended_type    blended_due[$];

   int error_count = 0;
   int results_checked = 0;
   int items_taken = 0;
   int settings_used = 0;
   int mode_tally[2] = '{0, 0};
   int presence_tally[4] = '{0, 0, 0, 0};

   rgba_pixel_compositor dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_a_red(req_a_red),
      .req_a_green(req_a_green),
      .req_a_blue(req_a_blue),
      .req_a_alpha(req_a_alpha),
      .req_b_red(req_b_red),
      .req_b_green(req_b_green),
      .req_b_blue(req_b_blue),
      .req_b_alpha(req_b_alpha),
      .req_a_present(req_a_present),
      .req_b_present(req_b_present),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_res_red(rsp_res_red),
      .rsp_res_green(rsp_res_green),
      .rsp_res_blue(rsp_res_blue),
      .rsp_res_alpha(rsp_res_alpha),
      .rsp_res_covered(rsp_res_covered)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [CB-1:0] sat_channel(longint unsigned v);
      logic [CB-1:0] r;
      r = (v > ONE - 1) ? '1 : v[CB-1:0];
      return r;
   endfunction

   // Copy a pixel with its alpha scaled by w; zero weight empties it.
   function automatic rgba_type scale_alpha(rgba_type p, longint unsigned w);
      rgba_type o;
      o = '0;
      if (w != 0) begin
         o = p;
         o.alpha = sat_channel((p.alpha * w) >> CB);
      end
      return o;
   endfunction

   function automatic rgba_type mix_pixels(rgba_type pa, rgba_type pb,
                                           longint unsigned wa, longint unsigned wb);
      longint unsigned sum;
      rgba_type o;
      sum = wa + wb;
      o = '0;
      if (sum != 0) begin
         o.red   = sat_channel((pa.red * wa + pb.red * wb) / sum);
         o.green = sat_channel((pa.green * wa + pb.green * wb) / sum);
         o.blue  = sat_channel((pa.blue * wa + pb.blue * wb) / sum);
         o.alpha = sat_channel(sum);
      end
      return o;
   endfunction

   function automatic blended_type predict_blend(pixel_pair_type px);
      longint unsigned mb;
      longint unsigned ma;
      longint unsigned wa;
      longint unsigned wb;
      blended_type o;
      mb = (mix_cfg > ONE) ? ONE : longint'(mix_cfg);
      ma = ONE - mb;
      o.color = '0;
      o.covered = px.a_present | px.b_present;
      if (mode_cfg == MODE_CROSSFADE) begin
         if (px.a_present && px.b_present) begin
            wa = (px.a.alpha * ma) >> CB;
            wb = (px.b.alpha * mb) >> CB;
            o.color = mix_pixels(px.a, px.b, wa, wb);
         end else if (px.a_present) begin
            o.color = scale_alpha(px.a, ma);
         end else if (px.b_present) begin
            o.color = scale_alpha(px.b, mb);
         end
      end else begin
         if (px.a_present && px.b_present) begin
            if (mb == 0) begin
               o.color = px.a;
            end else begin
               wb = (px.b.alpha * mb) >> CB;
               wa = (px.a.alpha * (ONE - wb)) >> CB;
               o.color = mix_pixels(px.a, px.b, wa, wb);
            end
         end else if (px.a_present) begin
            o.color = px.a;
         end else if (px.b_present) begin
            o.color = scale_alpha(px.b, mb);
         end
      end
      return o;
   endfunction

   task automatic report_error(string msg);
      if (error_count < 50) begin
         $display("ERROR @%0t: %s", $realtime, msg);
      end
      error_count++;
   endtask

   task automatic compare_field(string name, logic [CB-1:0] got, logic [CB-1:0] want);
      if (got !== want) begin
         report_error($sformatf("pixel %0d %s: got %h, want %h",
                                results_checked, name, got, want));
      end
   endtask

   task automatic write_csr(logic index, logic [CB:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == CSR_MIX_WEIGHT) begin
         mix_cfg = value;
      end else begin
         mode_cfg = value[0];
      end
   endtask

   task automatic send_pixel(rgba_type a, rgba_type b, logic ha, logic hb);
      pixels_to_send.push_back('{a, b, ha, hb});
   endtask

   function automatic logic [CB-1:0] rand_channel();
      logic [CB-1:0] v;
      case ($urandom_range(0, 7))
         0: v = '0;
         1: v = '1;
         2: v = CB'($urandom_range(0, 15));
         default: v = CB'($urandom);
      endcase
      return v;
   endfunction

   task automatic queue_random_pixels(int count);
      rgba_type a;
      rgba_type b;
      int pick;
      for (int i = 0; i < count; i++) begin
         a = '{rand_channel(), rand_channel(), rand_channel(), rand_channel()};
         b = '{rand_channel(), rand_channel(), rand_channel(), rand_channel()};
         pick = $urandom_range(0, 9);
         // mostly overlapping windows, some edges, a few misses
         send_pixel(a, b, pick < 7 || pick == 7, pick < 7 || pick == 8);
      end
   endtask

   task automatic wait_for_drain();
      while (pixels_to_send.size() > 0 || req_valid || blended_due.size() > 0) begin
         @(negedge clock);
      end
      settings_used++;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values: mix zero, crossfade
      send_pixel(FULL_PX, FULL_PX, 1'b0, 1'b0);
      send_pixel(MID_PX, FULL_PX, 1'b1, 1'b0);
      send_pixel(FULL_PX, MID_PX, 1'b0, 1'b1);
      send_pixel(FULL_PX, FULL_PX, 1'b1, 1'b1);
      wait_for_drain();

      write_csr(CSR_MIX_WEIGHT, MIX_UNITY);
      write_csr(CSR_BLEND_MODE, {CB+1{1'b0}});
      @(negedge clock);
      send_pixel(MID_PX, FULL_PX, 1'b1, 1'b0);
      send_pixel(FULL_PX, MID_PX, 1'b0, 1'b1);
      send_pixel(MID_PX, FULL_PX, 1'b1, 1'b1);
      send_pixel(CLEAR_PX, CLEAR_PX, 1'b1, 1'b1);
      wait_for_drain();

      // over mode, written with the upper data bits set
      write_csr(CSR_MIX_WEIGHT, MIX_UNITY >> 1);
      write_csr(CSR_BLEND_MODE, '1);
      @(negedge clock);
      send_pixel(MID_PX, FULL_PX, 1'b1, 1'b1);
      send_pixel(CLEAR_PX, CLEAR_PX, 1'b1, 1'b1);
      send_pixel(MID_PX, FULL_PX, 1'b1, 1'b0);
      send_pixel(MID_PX, FULL_PX, 1'b0, 1'b1);
      send_pixel(FULL_PX, FULL_PX, 1'b0, 1'b0);
      send_pixel(FULL_PX, EMPTY_PX, 1'b1, 1'b1);
      wait_for_drain();

      write_csr(CSR_MIX_WEIGHT, '0);
      @(negedge clock);
      send_pixel(MID_PX, FULL_PX, 1'b1, 1'b1);
      send_pixel(MID_PX, FULL_PX, 1'b0, 1'b1);
      wait_for_drain();

      // above unity clamps
      write_csr(CSR_MIX_WEIGHT, '1);
      @(negedge clock);
      send_pixel(MID_PX, FULL_PX, 1'b1, 1'b1);
      send_pixel(MID_PX, MID_PX, 1'b0, 1'b1);
      wait_for_drain();

      for (int k = 0; k < RANDOM_PHASES; k++) begin
         logic [CB:0] mix;
         logic [CB:0] mode_word;
         case (k % 6)
            0: mix = '0;
            1: mix = MIX_UNITY;
            2: mix = (CB + 1)'($urandom_range(MIX_UNITY + 1, (1 << (CB + 1)) - 1));
            3: mix = (CB + 1)'(1);
            4: mix = MIX_UNITY - 1;
            default: mix = (CB + 1)'($urandom_range(0, MIX_UNITY));
         endcase
         mode_word = (CB + 1)'($urandom);
         mode_word[0] = ((k / 6) % 2 == 0) ? MODE_CROSSFADE : MODE_OVER;
         write_csr(CSR_MIX_WEIGHT, mix);
         write_csr(CSR_BLEND_MODE, mode_word);
         @(negedge clock);
         queue_random_pixels(ITEMS_PER_PHASE);
         wait_for_drain();
      end

      repeat (LATENCY + 10) @(posedge clock);
      if (blended_due.size() != 0) begin
         report_error($sformatf("%0d results never arrived", blended_due.size()));
      end
      $display("Covered %0d pixels over %0d register settings (crossfade %0d, over %0d).",
               results_checked, settings_used, mode_tally[0], mode_tally[1]);
      $display("Window overlap: both %0d, only A %0d, only B %0d, neither %0d; errors %0d.",
               presence_tally[3], presence_tally[2], presence_tally[1], presence_tally[0],
               error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Driver: bursts of items with random gaps between them
   int burst_left = 1;
   int gap_left = 0;
   logic valid_next;
   pixel_pair_type drive_px;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = $urandom_range(1, 48);
         gap_left = 0;
      end else begin
         valid_next = req_valid;
         if (req_valid && !req_stall) valid_next = 1'b0;
         if (!valid_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pixels_to_send.size() > 0) begin
               drive_px = pixels_to_send.pop_front();
               req_a_red     <= drive_px.a.red;
               req_a_green   <= drive_px.a.green;
               req_a_blue    <= drive_px.a.blue;
               req_a_alpha   <= drive_px.a.alpha;
               req_b_red     <= drive_px.b.red;
               req_b_green   <= drive_px.b.green;
               req_b_blue    <= drive_px.b.blue;
               req_b_alpha   <= drive_px.b.alpha;
               req_a_present <= drive_px.a_present;
               req_b_present <= drive_px.b_present;
               valid_next = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 48);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
         req_valid <= valid_next;
      end
   end

   // Receiver stall pattern, plus one long hold to back up the pipe
   int hold_left = 0;
   bit hold_done = 1'b0;
   int stall_cycle = 0;
   logic stall_next;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
         stall_cycle = 0;
      end else begin
         stall_cycle++;
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (!hold_done && items_taken >= HOLD_AFTER_ITEMS) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
            stall_next = 1'b1;
         end else begin
            case ((stall_cycle / 211) % 4)
               0: stall_next = 1'b0;
               1: stall_next = ($urandom_range(0, 3) == 0);
               2: stall_next = ($urandom_range(0, 3) != 0);
               default: stall_next = ((stall_cycle % 7) < 3);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   // Monitor: check results first, then predict for the item taken this edge
   blended_type    seen_blend;
   blended_type    due_blend;
   pixel_pair_type taken_px;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen_blend.color = '{rsp_res_red, rsp_res_green, rsp_res_blue, rsp_res_alpha};
            seen_blend.covered = rsp_res_covered;
            if (blended_due.size() == 0) begin
               report_error("result arrived with no pixel outstanding");
            end else begin
               due_blend = blended_due.pop_front();
               compare_field("red", seen_blend.color.red, due_blend.color.red);
               compare_field("green", seen_blend.color.green, due_blend.color.green);
               compare_field("blue", seen_blend.color.blue, due_blend.color.blue);
               compare_field("alpha", seen_blend.color.alpha, due_blend.color.alpha);
               compare_field("covered", CB'(seen_blend.covered), CB'(due_blend.covered));
            end
            results_checked++;
         end
         if (req_valid && !req_stall) begin
            taken_px.a = '{req_a_red, req_a_green, req_a_blue, req_a_alpha};
            taken_px.b = '{req_b_red, req_b_green, req_b_blue, req_b_alpha};
            taken_px.a_present = req_a_present;
            taken_px.b_present = req_b_present;
            blended_due.push_back(predict_blend(taken_px));
            mode_tally[mode_cfg]++;
            presence_tally[{req_a_present, req_b_present}]++;
            items_taken <= items_taken + 1;
         end
      end
   end

   // Watchdog: no handshake on any channel for too long
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR @%0t: no handshake for %0d cycles, %0d results outstanding",
                  $realtime, idle_cycles, blended_due.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
